[rtl/lrcr_pkg.sv]
// ----------------------------------------------------------------------------
// lrcr_pkg: shared types and constants
// Command and result formats, field widths and pipeline depths for the
// luminance ratio color restore block.
// ----------------------------------------------------------------------------
package lrcr_pkg;

  localparam int PIX_W       = 8;           // every byte field
  localparam int TABLE_AW    = 16;          // table index: blurred level, gray level
  localparam int TABLE_DEPTH = 65536;
  localparam int GAIN_W      = 5;
  localparam int SUM_W       = 10;          // sum of three table levels, up to 765
  localparam int DEN_W       = 10;          // three times gray, up to 765
  localparam int NUM_W       = 18;          // channel times sum, up to 195075
  localparam int LIM_W       = 15;          // three times gray times gain, up to 23715
  localparam int SATP_W      = 13;          // channel times gain, up to 7905
  localparam int QUO_W       = 8;           // quotient bits before saturation
  localparam int NCH         = 3;
  localparam int NBLUR       = 3;

  localparam int CH_BLUE     = 0;
  localparam int CH_GREEN    = 1;
  localparam int CH_RED      = 2;
  localparam int BLUR_SMALL  = 0;
  localparam int BLUR_MID    = 1;
  localparam int BLUR_LARGE  = 2;
  localparam int WDATA_SLOT  = 0;           // channel slot that carries table data

  localparam logic [GAIN_W-1:0] GAIN_RESET = 5'd4;
  localparam logic [PIX_W-1:0]  PIX_MAX    = 8'd255;

  // divider: entry stage, one stage per quotient bit, rounding stage
  localparam int DIV_LAT  = QUO_W + 2;
  // three front stages of the back pipeline ahead of the divider
  localparam int BACK_LAT = DIV_LAT + 3;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_PIXEL = 1'b1
  } cmd_kind_t;

  // A table write reuses the pixel layout: gray holds the low address byte,
  // every blur slot holds the high address byte, data sits in WDATA_SLOT.
  typedef struct packed {
    cmd_kind_t                   kind;
    logic [PIX_W-1:0]            gray;
    logic [NBLUR-1:0][PIX_W-1:0] blur;
    logic [NCH-1:0][PIX_W-1:0]   chan;
  } cmd_t;

  typedef struct packed {
    logic [NCH-1:0][PIX_W-1:0] chan;
  } pix_t;

endpackage

[rtl/luminance_ratio_color_restore.sv]
// ----------------------------------------------------------------------------
// luminance_ratio_color_restore: per-pixel color restore after luminance
// enhancement
//
// Channel   Handshake              Payload
// input     push / full            func, table_address, table_value,
//                                  gray_level, blur_small/mid/large,
//                                  blue_in, green_in, red_in
// result    empty / pop            blue_out, green_out, red_out
// config    cfg_valid / cfg_ready  cfg_data (max_gain)
//
// One item per clock while full is low; a table write gives no result.
// A pixel waits in the command queue, then passes 13 back stages that
// include the 8-step quotient pipeline before it reaches the result queue.
// Reset (rst, synchronous) empties both queues, clears the pipeline valid
// bits and sets max_gain to 4; the table is not cleared and must be written
// before it is read. Pixels leave the command queue only with a result
// queue slot reserved, so a stalled reader stops input through full.
// ----------------------------------------------------------------------------
module luminance_ratio_color_restore #(
  parameter int CMD_DEPTH    = 4,
  parameter int RESULT_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // input queue side
  input  logic                          push,
  output logic                          full,
  input  logic                          func,
  input  logic [lrcr_pkg::TABLE_AW-1:0] table_address,
  input  logic [lrcr_pkg::PIX_W-1:0]    table_value,
  input  logic [lrcr_pkg::PIX_W-1:0]    gray_level,
  input  logic [lrcr_pkg::PIX_W-1:0]    blur_small,
  input  logic [lrcr_pkg::PIX_W-1:0]    blur_mid,
  input  logic [lrcr_pkg::PIX_W-1:0]    blur_large,
  input  logic [lrcr_pkg::PIX_W-1:0]    blue_in,
  input  logic [lrcr_pkg::PIX_W-1:0]    green_in,
  input  logic [lrcr_pkg::PIX_W-1:0]    red_in,
  // result queue side
  output logic                          empty,
  input  logic                          pop,
  output logic [lrcr_pkg::PIX_W-1:0]    blue_out,
  output logic [lrcr_pkg::PIX_W-1:0]    green_out,
  output logic [lrcr_pkg::PIX_W-1:0]    red_out,
  // configuration write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lrcr_pkg::GAIN_W-1:0]   cfg_data
);

  localparam int RES_W = $bits(lrcr_pkg::pix_t);

  logic [lrcr_pkg::GAIN_W-1:0] max_gain;

  logic             cmd_valid;
  lrcr_pkg::cmd_t   cmd;
  logic             cmd_pop;

  logic             res_push;
  logic             res_full;
  logic             res_pop;
  lrcr_pkg::pix_t   res;
  logic [RES_W-1:0] res_rdata;
  lrcr_pkg::pix_t   res_out;

  // Gain limit register: always ready, one transaction per valid cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_gain <= lrcr_pkg::GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_gain <= cfg_data;
    end
  end

  // Front: classify and queue incoming transactions.
  lrcr_front #(
    .CMD_DEPTH (CMD_DEPTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .func          (func),
    .table_address (table_address),
    .table_value   (table_value),
    .gray_level    (gray_level),
    .blur_small    (blur_small),
    .blur_mid      (blur_mid),
    .blur_large    (blur_large),
    .blue_in       (blue_in),
    .green_in      (green_in),
    .red_in        (red_in),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop)
  );

  // Back: table access and gain arithmetic; it counts result slots,
  // so it needs to see every result transaction that leaves.
  assign res_pop = pop & ~empty;

  lrcr_back #(
    .RES_DEPTH (RESULT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .max_gain  (max_gain),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_pop   (res_pop),
    .res_push  (res_push),
    .res       (res)
  );

  // Result queue: holds finished pixels while the reader stalls.
  lrcr_fifo #(
    .WIDTH (RES_W),
    .DEPTH (RESULT_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  assign res_out   = lrcr_pkg::pix_t'(res_rdata);
  assign blue_out  = res_out.chan[lrcr_pkg::CH_BLUE];
  assign green_out = res_out.chan[lrcr_pkg::CH_GREEN];
  assign red_out   = res_out.chan[lrcr_pkg::CH_RED];

`ifndef SYNTHESIS
  // Slot reservation must keep the result queue from overflowing.
  a_res_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into a full result queue");

  // A result only appears a fixed pipeline depth after a command was taken.
  a_res_latency: assert property (@(posedge clk) disable iff (rst)
    res_push |-> $past(cmd_pop, lrcr_pkg::BACK_LAT))
    else $error("result without a command issued at the pipeline depth");

  // A full command queue always offers a command to the back end.
  a_cmd_full_valid: assert property (@(posedge clk) disable iff (rst)
    full |-> cmd_valid)
    else $error("command queue full but no command offered");
`endif

endmodule

[rtl/lrcr_fifo.sv]
// ----------------------------------------------------------------------------
// lrcr_fifo: small register queue
// Circular buffer with occupancy count; push ignored when full, pop when empty.
// ----------------------------------------------------------------------------
module lrcr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= wdata;
    end
  end

endmodule

[rtl/lrcr_front.sv]
// ----------------------------------------------------------------------------
// lrcr_front: input side
// Classify each item as table write or pixel, pack it into one command
// format and hold it in the command queue until the back end takes it.
// ----------------------------------------------------------------------------
module lrcr_front #(
  parameter int CMD_DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic                         func,
  input  logic [lrcr_pkg::TABLE_AW-1:0] table_address,
  input  logic [lrcr_pkg::PIX_W-1:0]   table_value,
  input  logic [lrcr_pkg::PIX_W-1:0]   gray_level,
  input  logic [lrcr_pkg::PIX_W-1:0]   blur_small,
  input  logic [lrcr_pkg::PIX_W-1:0]   blur_mid,
  input  logic [lrcr_pkg::PIX_W-1:0]   blur_large,
  input  logic [lrcr_pkg::PIX_W-1:0]   blue_in,
  input  logic [lrcr_pkg::PIX_W-1:0]   green_in,
  input  logic [lrcr_pkg::PIX_W-1:0]   red_in,
  output logic                         cmd_valid,
  output lrcr_pkg::cmd_t               cmd,
  input  logic                         cmd_pop
);

  localparam int CMD_W = $bits(lrcr_pkg::cmd_t);

  lrcr_pkg::cmd_t   cmd_in;
  logic [CMD_W-1:0] q_rdata;
  logic             q_empty;

  always_comb begin
    cmd_in      = '0;
    cmd_in.kind = lrcr_pkg::cmd_kind_t'(func);
    unique case (cmd_in.kind)
      lrcr_pkg::CMD_WRITE: begin
        // same entry in every table copy
        cmd_in.gray = table_address[lrcr_pkg::PIX_W-1:0];
        for (int k = 0; k < lrcr_pkg::NBLUR; k++) begin
          cmd_in.blur[k] = table_address[lrcr_pkg::TABLE_AW-1:lrcr_pkg::PIX_W];
        end
        cmd_in.chan[lrcr_pkg::WDATA_SLOT] = table_value;
      end
      lrcr_pkg::CMD_PIXEL: begin
        cmd_in.gray                        = gray_level;
        cmd_in.blur[lrcr_pkg::BLUR_SMALL]  = blur_small;
        cmd_in.blur[lrcr_pkg::BLUR_MID]    = blur_mid;
        cmd_in.blur[lrcr_pkg::BLUR_LARGE]  = blur_large;
        cmd_in.chan[lrcr_pkg::CH_BLUE]     = blue_in;
        cmd_in.chan[lrcr_pkg::CH_GREEN]    = green_in;
        cmd_in.chan[lrcr_pkg::CH_RED]      = red_in;
      end
      default: begin
        cmd_in.gray = gray_level;
      end
    endcase
  end

  lrcr_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign cmd_valid = ~q_empty;
  assign cmd       = lrcr_pkg::cmd_t'(q_rdata);

endmodule

[rtl/lrcr_div.sv]
// ----------------------------------------------------------------------------
// lrcr_div: pipelined rounding divider for one channel
// num / den, one quotient bit per stage, rounded half to even and saturated
// to a byte; a fixed value replaces the quotient when sel_fix is set.
// ----------------------------------------------------------------------------
module lrcr_div (
  input  logic                        clk,
  input  logic [lrcr_pkg::NUM_W-1:0]  num,
  input  logic [lrcr_pkg::DEN_W-1:0]  den,
  input  logic                        sel_fix,
  input  logic [lrcr_pkg::PIX_W-1:0]  fix_val,
  output logic [lrcr_pkg::QUO_W-1:0]  quo
);

  localparam int NUM_W = lrcr_pkg::NUM_W;
  localparam int DEN_W = lrcr_pkg::DEN_W;
  localparam int QUO_W = lrcr_pkg::QUO_W;
  localparam int RW    = NUM_W + 1;

  logic [NUM_W-1:0] st_rem  [QUO_W+1];
  logic [DEN_W-1:0] st_den  [QUO_W+1];
  logic [QUO_W-1:0] st_q    [QUO_W+1];
  logic             st_done [QUO_W+1];
  logic [QUO_W-1:0] st_dval [QUO_W+1];

  logic [NUM_W-1:0] trial   [QUO_W];
  logic             ge      [QUO_W];

  logic             ovf;
  logic [RW-1:0]    twice_r;
  logic [RW-1:0]    den_ext;
  logic             round_up;
  logic [QUO_W:0]   q_rnd;
  logic [QUO_W-1:0] q_final;

  // quotient of 256 or more always saturates
  assign ovf = (num >= NUM_W'({den, {QUO_W{1'b0}}}));

  always_comb begin
    for (int j = 0; j < QUO_W; j++) begin
      trial[j] = NUM_W'(st_den[j]) << (QUO_W - 1 - j);
      ge[j]    = (st_rem[j] >= trial[j]);
    end
  end

  always_comb begin
    twice_r  = {st_rem[QUO_W], 1'b0};
    den_ext  = RW'(st_den[QUO_W]);
    round_up = (twice_r > den_ext) || ((twice_r == den_ext) && st_q[QUO_W][0]);
    q_rnd    = {1'b0, st_q[QUO_W]} + (QUO_W + 1)'(round_up);
    q_final  = q_rnd[QUO_W] ? {QUO_W{1'b1}} : q_rnd[QUO_W-1:0];
  end

  always_ff @(posedge clk) begin
    st_rem[0]  <= num;
    st_den[0]  <= den;
    st_q[0]    <= '0;
    st_done[0] <= sel_fix | ovf;
    st_dval[0] <= sel_fix ? fix_val : {QUO_W{1'b1}};
    for (int j = 0; j < QUO_W; j++) begin
      st_rem[j+1]  <= ge[j] ? st_rem[j] - trial[j] : st_rem[j];
      st_den[j+1]  <= st_den[j];
      st_q[j+1]    <= {st_q[j][QUO_W-2:0], ge[j]};
      st_done[j+1] <= st_done[j];
      st_dval[j+1] <= st_dval[j];
    end
    quo <= st_done[QUO_W] ? st_dval[QUO_W] : q_final;
  end

endmodule

[rtl/lrcr_back.sv]
// ----------------------------------------------------------------------------
// lrcr_back: execution side
// Table copies, level sum, gain limit and per-channel dividers. Issues a
// pixel only when a result queue slot is reserved for it.
// ----------------------------------------------------------------------------
module lrcr_back #(
  parameter int RES_DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [lrcr_pkg::GAIN_W-1:0]  max_gain,
  input  logic                         cmd_valid,
  input  lrcr_pkg::cmd_t               cmd,
  output logic                         cmd_pop,
  input  logic                         res_pop,
  output logic                         res_push,
  output lrcr_pkg::pix_t               res
);

  localparam int PIX_W    = lrcr_pkg::PIX_W;
  localparam int NCH      = lrcr_pkg::NCH;
  localparam int NBLUR    = lrcr_pkg::NBLUR;
  localparam int SUM_W    = lrcr_pkg::SUM_W;
  localparam int DEN_W    = lrcr_pkg::DEN_W;
  localparam int NUM_W    = lrcr_pkg::NUM_W;
  localparam int LIM_W    = lrcr_pkg::LIM_W;
  localparam int SATP_W   = lrcr_pkg::SATP_W;
  localparam int BACK_LAT = lrcr_pkg::BACK_LAT;
  localparam int CRW      = $clog2(RES_DEPTH + 1);

  // reservation count: pixels issued whose results are not yet popped
  logic [CRW-1:0]   credit;
  logic             room;
  logic             is_write;
  logic             issue_wr;
  logic             issue_pix;
  logic [BACK_LAT-1:0] vld;

  logic [PIX_W-1:0] tbl [NBLUR][lrcr_pkg::TABLE_DEPTH];
  logic [lrcr_pkg::TABLE_AW-1:0] addr [NBLUR];
  logic [PIX_W-1:0] rd_lvl [NBLUR];

  logic [PIX_W-1:0]  gray1;
  logic [PIX_W-1:0]  chan1 [NCH];

  logic [SUM_W-1:0]  t2;
  logic [DEN_W-1:0]  den2;
  logic              gz2;
  logic [PIX_W-1:0]  chan2 [NCH];

  logic [SUM_W-1:0]  t3;
  logic [DEN_W-1:0]  den3;
  logic              gz3;
  logic [LIM_W-1:0]  lim3;
  logic [NUM_W-1:0]  num3  [NCH];
  logic [SATP_W-1:0] satp3 [NCH];

  logic              sel_fix;
  logic [PIX_W-1:0]  fix_val [NCH];
  logic [PIX_W-1:0]  quo     [NCH];

  assign room      = (credit != CRW'(RES_DEPTH));
  assign is_write  = (cmd.kind == lrcr_pkg::CMD_WRITE);
  assign cmd_pop   = cmd_valid & (is_write | room);
  assign issue_wr  = cmd_pop & is_write;
  assign issue_pix = cmd_pop & ~is_write;

  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= '0;
      vld    <= '0;
    end else begin
      credit <= credit + CRW'(issue_pix) - CRW'(res_pop);
      vld    <= {vld[BACK_LAT-2:0], issue_pix};
    end
  end

  // one table copy per blur scale, so all three lookups happen in the same cycle
  always_comb begin
    for (int k = 0; k < NBLUR; k++) begin
      addr[k] = {cmd.blur[k], cmd.gray};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NBLUR; k++) begin
      if (issue_wr) begin
        tbl[k][addr[k]] <= cmd.chan[lrcr_pkg::WDATA_SLOT];
      end
      if (issue_pix) begin
        rd_lvl[k] <= tbl[k][addr[k]];
      end
    end
  end

  // stage 1: carry pixel fields beside the table read
  always_ff @(posedge clk) begin
    gray1 <= cmd.gray;
    for (int c = 0; c < NCH; c++) begin
      chan1[c] <= cmd.chan[c];
    end
  end

  // stage 2: level sum and divisor
  always_ff @(posedge clk) begin
    t2   <= SUM_W'(rd_lvl[0]) + SUM_W'(rd_lvl[1]) + SUM_W'(rd_lvl[2]);
    den2 <= DEN_W'({gray1, 1'b0}) + DEN_W'(gray1);
    gz2  <= (gray1 == '0);
    for (int c = 0; c < NCH; c++) begin
      chan2[c] <= chan1[c];
    end
  end

  // stage 3: products
  always_ff @(posedge clk) begin
    t3   <= t2;
    den3 <= den2;
    gz3  <= gz2;
    lim3 <= LIM_W'(den2) * LIM_W'(max_gain);
    for (int c = 0; c < NCH; c++) begin
      num3[c]  <= NUM_W'(chan2[c]) * NUM_W'(t2);
      satp3[c] <= SATP_W'(chan2[c]) * SATP_W'(max_gain);
    end
  end

  // gain limited: channel times max_gain, saturated
  always_comb begin
    sel_fix = gz3 | (LIM_W'(t3) >= lim3);
    for (int c = 0; c < NCH; c++) begin
      fix_val[c] = (satp3[c] > SATP_W'(lrcr_pkg::PIX_MAX)) ? lrcr_pkg::PIX_MAX
                                                         : satp3[c][PIX_W-1:0];
    end
  end

  for (genvar c = 0; c < NCH; c++) begin : g_div
    lrcr_div u_div (
      .clk     (clk),
      .num     (num3[c]),
      .den     (den3),
      .sel_fix (sel_fix),
      .fix_val (fix_val[c]),
      .quo     (quo[c])
    );
  end

  assign res_push = vld[BACK_LAT-1];

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      res.chan[c] = quo[c];
    end
  end

endmodule

[verif/tb_luminance_ratio_color_restore.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_luminance_ratio_color_restore: self-checking bench for the color restore
// Loads table entries ahead of every pixel that reads them. Predicts each
// pixel's restored channels with an exact rational gain and checks every
// result transaction in order. Steps the gain limit across its whole range,
// and idles both the pixel source and the result reader at random.
// ----------------------------------------------------------------------------
module tb_luminance_ratio_color_restore;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_ITEMS  = 285;
  localparam int NUM_PHASES   = 7;
  localparam int IDLE_PERCENT = 37;

  localparam int PIX_W    = lrcr_pkg::PIX_W;
  localparam int TABLE_AW = lrcr_pkg::TABLE_AW;
  localparam int GAIN_W   = lrcr_pkg::GAIN_W;
  localparam int NBLUR    = lrcr_pkg::NBLUR;
  localparam int NCH      = lrcr_pkg::NCH;

  // One input transaction: a table write or a pixel. Fields that a kind does
  // not use carry random noise.
  typedef struct {
    lrcr_pkg::cmd_kind_t         kind;
    logic [TABLE_AW-1:0]         addr;
    logic [PIX_W-1:0]            value;
    logic [PIX_W-1:0]            gray;
    logic [NBLUR-1:0][PIX_W-1:0] blur;
    logic [NCH-1:0][PIX_W-1:0]   chan;
  } lrcr_item_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                push = 1'b0;
  logic                full;
  logic                func = 1'b0;
  logic [TABLE_AW-1:0] table_address = '0;
  logic [PIX_W-1:0]    table_value = '0;
  logic [PIX_W-1:0]    gray_level = '0;
  logic [PIX_W-1:0]    blur_small = '0;
  logic [PIX_W-1:0]    blur_mid = '0;
  logic [PIX_W-1:0]    blur_large = '0;
  logic [PIX_W-1:0]    blue_in = '0;
  logic [PIX_W-1:0]    green_in = '0;
  logic [PIX_W-1:0]    red_in = '0;
  logic                empty;
  logic                pop = 1'b0;
  logic [PIX_W-1:0]    blue_out;
  logic [PIX_W-1:0]    green_out;
  logic [PIX_W-1:0]    red_out;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [GAIN_W-1:0]   cfg_data = '0;

  // Items waiting to be pushed, and restored pixels waiting to come out.
  lrcr_item_t     pending_q[$];
  lrcr_pkg::pix_t restored_q[$];

  // Bench copy of the block state: table contents and the active gain limit.
  logic [PIX_W-1:0]  level_tab [lrcr_pkg::TABLE_DEPTH];
  logic [GAIN_W-1:0] gain_limit = lrcr_pkg::GAIN_RESET;

  // Entries already loaded at generation time; pixels only read these.
  bit          loaded_map [lrcr_pkg::TABLE_DEPTH];
  int unsigned gen_count = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  bit          steady = 1'b0;

  luminance_ratio_color_restore dut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .func          (func),
    .table_address (table_address),
    .table_value   (table_value),
    .gray_level    (gray_level),
    .blur_small    (blur_small),
    .blur_mid      (blur_mid),
    .blur_large    (blur_large),
    .blue_in       (blue_in),
    .green_in      (green_in),
    .red_in        (red_in),
    .empty         (empty),
    .pop           (pop),
    .blue_out      (blue_out),
    .green_out     (green_out),
    .red_out       (red_out),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Scale one channel by the gain sum / (3 * gray), capped at the gain limit.
  // The ratio path rounds to nearest with ties to even; everything saturates.
  function automatic logic [PIX_W-1:0] restore_channel(int unsigned ch, int unsigned sum,
                                                       int unsigned gray, int unsigned gain);
    int unsigned scaled;
    int unsigned den;
    int unsigned rem;
    if (gray == 0 || sum >= 3 * gain * gray) begin
      scaled = ch * gain;
    end else begin
      den    = 3 * gray;
      scaled = (ch * sum) / den;
      rem    = (ch * sum) % den;
      if (2 * rem > den || (2 * rem == den && (scaled % 2) == 1)) begin
        scaled++;
      end
    end
    return (scaled > lrcr_pkg::PIX_MAX) ? lrcr_pkg::PIX_MAX : scaled[PIX_W-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Queue a table write; the pixel fields carry noise.
  task automatic add_write(input logic [TABLE_AW-1:0] addr, input logic [PIX_W-1:0] value);
    lrcr_item_t item;
    item.kind  = lrcr_pkg::CMD_WRITE;
    item.addr  = addr;
    item.value = value;
    item.gray  = PIX_W'($urandom);
    item.blur  = (NBLUR*PIX_W)'($urandom);
    item.chan  = (NCH*PIX_W)'($urandom);
    loaded_map[addr] = 1'b1;
    pending_q.push_back(item);
    gen_count++;
  endtask

  // Queue a pixel, loading any entry it reads that was never written.
  task automatic add_pixel(input logic [PIX_W-1:0] gray,
                           input logic [NBLUR-1:0][PIX_W-1:0] blur,
                           input logic [NCH-1:0][PIX_W-1:0] chan);
    lrcr_item_t item;
    for (int i = 0; i < NBLUR; i++) begin
      if (!loaded_map[{blur[i], gray}]) begin
        add_write({blur[i], gray}, PIX_W'($urandom_range(255)));
      end
    end
    item.kind  = lrcr_pkg::CMD_PIXEL;
    item.addr  = TABLE_AW'($urandom);
    item.value = PIX_W'($urandom);
    item.gray  = gray;
    item.blur  = blur;
    item.chan  = chan;
    pending_q.push_back(item);
    gen_count++;
  endtask

  // Wait until every item is in and every pixel is out, then let trailing
  // table writes and the pipeline drain.
  task automatic settle();
    while (pending_q.size() != 0 || restored_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (lrcr_pkg::BACK_LAT + 8) @(negedge clk);
  endtask

  // Driver: on each accepted transaction update the bench table or predict
  // the restored pixel, then present the next pending item unless idling.
  always @(posedge clk) begin : drive_proc
    int unsigned    lum_sum;
    lrcr_pkg::pix_t want;
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        if (pending_q[0].kind == lrcr_pkg::CMD_WRITE) begin
          level_tab[pending_q[0].addr] = pending_q[0].value;
        end else begin
          lum_sum = 0;
          for (int i = 0; i < NBLUR; i++) begin
            lum_sum += level_tab[{pending_q[0].blur[i], pending_q[0].gray}];
          end
          for (int c = 0; c < NCH; c++) begin
            want.chan[c] = restore_channel(pending_q[0].chan[c], lum_sum,
                                           pending_q[0].gray, gain_limit);
          end
          restored_q.push_back(want);
        end
        void'(pending_q.pop_front());
      end
      if (pending_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
        push          <= 1'b1;
        func          <= pending_q[0].kind;
        table_address <= pending_q[0].addr;
        table_value   <= pending_q[0].value;
        gray_level    <= pending_q[0].gray;
        blur_small    <= pending_q[0].blur[lrcr_pkg::BLUR_SMALL];
        blur_mid      <= pending_q[0].blur[lrcr_pkg::BLUR_MID];
        blur_large    <= pending_q[0].blur[lrcr_pkg::BLUR_LARGE];
        blue_in       <= pending_q[0].chan[lrcr_pkg::CH_BLUE];
        green_in      <= pending_q[0].chan[lrcr_pkg::CH_GREEN];
        red_in        <= pending_q[0].chan[lrcr_pkg::CH_RED];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Monitor: compare each popped result with the oldest prediction,
  // channel by channel, and stall the reader at random.
  always @(posedge clk) begin : check_proc
    lrcr_pkg::pix_t want;
    lrcr_pkg::pix_t got;
    string          chan_name [NCH];
    chan_name[lrcr_pkg::CH_BLUE]  = "blue_out";
    chan_name[lrcr_pkg::CH_GREEN] = "green_out";
    chan_name[lrcr_pkg::CH_RED]   = "red_out";
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        got.chan[lrcr_pkg::CH_BLUE]  = blue_out;
        got.chan[lrcr_pkg::CH_GREEN] = green_out;
        got.chan[lrcr_pkg::CH_RED]   = red_out;
        if (restored_q.size() == 0) begin
          report_mismatch($sformatf("result %0h with no pixel pending", got));
        end else begin
          want = restored_q.pop_front();
          for (int c = 0; c < NCH; c++) begin
            if (got.chan[c] !== want.chan[c]) begin
              report_mismatch($sformatf("%s got %0d want %0d", chan_name[c],
                                        got.chan[c], want.chan[c]));
            end
          end
        end
      end
      pop <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // Watchdog: a hung handshake ends the run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : sequence_proc
    logic [GAIN_W-1:0]           gain_plan [NUM_PHASES];
    logic [PIX_W-1:0]            gray_pick;
    logic [NBLUR-1:0][PIX_W-1:0] blur_pick;
    logic [NCH-1:0][PIX_W-1:0]   chan_pick;
    int unsigned                 phase_end;

    // Reset value first, then both range ends, the out-of-range corners
    // (zero gain, largest encodable gain) and two random settings.
    gain_plan[0] = lrcr_pkg::GAIN_RESET;
    gain_plan[1] = 5'd16;
    gain_plan[2] = 5'd1;
    gain_plan[3] = 5'd0;
    gain_plan[4] = 5'd31;
    gain_plan[5] = GAIN_W'($urandom_range(1, 16));
    gain_plan[6] = GAIN_W'($urandom_range(31));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p != 0) begin
        // Hold the source until every result is back, then retune the gain.
        settle();
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= gain_plan[p];
        do @(posedge clk); while (!cfg_ready);
        gain_limit = gain_plan[p];
        cfg_valid <= 1'b0;
      end
      @(negedge clk);
      // One phase runs with neither side idling.
      steady = (p == 1);

      if (p == 0) begin
        // Zero gray with an all-zero sum: the gain falls back to the limit.
        add_write(16'h0000, 8'd0);
        add_pixel(8'd0, {3{8'd0}}, {8'd64, 8'd255, 8'd0});
        // Top corner of the table: sum 765 over gray 255 is a unit gain.
        add_write(16'hFFFF, 8'd255);
        add_pixel(8'd255, {3{8'd255}}, {8'd128, 8'd0, 8'd255});
        // Rounding ties at gray 2: odd quotient rounds up, even one stays.
        add_write({8'd2, 8'd2}, 8'd3);
        add_write({8'd3, 8'd2}, 8'd1);
        add_pixel(8'd2, {3{8'd2}}, {8'd255, 8'd3, 8'd1});
        add_pixel(8'd2, {3{8'd3}}, {8'd5, 8'd3, 8'd1});
        // Large sum over gray 1 hits the gain limit.
        add_write({8'd10, 8'd1}, 8'd255);
        add_pixel(8'd1, {3{8'd10}}, {8'd64, 8'd63, 8'd1});
        // Zero gray with a nonzero sum and mixed blur levels.
        add_write({8'd7, 8'd0}, 8'd200);
        add_pixel(8'd0, {8'd0, 8'd7, 8'd7}, {8'd1, 8'd100, 8'd33});
        // Sum exactly at the limit threshold.
        add_write({8'd5, 8'd20}, 8'd80);
        add_pixel(8'd20, {3{8'd5}}, {8'd10, 8'd200, 8'd0});
        // Overwrite before read, then read, rewrite and read again.
        add_write({8'd40, 8'd50}, 8'd11);
        add_write({8'd40, 8'd50}, 8'd170);
        add_pixel(8'd50, {3{8'd40}}, {8'd90, 8'd45, 8'd255});
        add_write({8'd40, 8'd50}, 8'd3);
        add_pixel(8'd50, {3{8'd40}}, {8'd90, 8'd45, 8'd255});
      end

      // Random part: mostly pixels, each preceded by the loads it needs,
      // with stray writes scattered over the whole table.
      phase_end = gen_count + PHASE_ITEMS;
      while (gen_count < phase_end) begin
        if ($urandom_range(9) == 0) begin
          add_write(TABLE_AW'($urandom_range(65535)), PIX_W'($urandom_range(255)));
        end else begin
          gray_pick = PIX_W'($urandom_range(255));
          if ($urandom_range(7) == 0) begin
            gray_pick = PIX_W'($urandom_range(3));
          end
          for (int i = 0; i < NBLUR; i++) begin
            blur_pick[i] = ($urandom_range(2) == 0) ? gray_pick
                                                     : PIX_W'($urandom_range(255));
          end
          for (int c = 0; c < NCH; c++) begin
            if ($urandom_range(7) == 0) begin
              chan_pick[c] = $urandom_range(1) ? lrcr_pkg::PIX_MAX : 8'd0;
            end else begin
              chan_pick[c] = PIX_W'($urandom_range(255));
            end
          end
          add_pixel(gray_pick, blur_pick, chan_pick);
        end
      end
    end

    settle();
    if (mismatches == 0 && restored_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
